// ===== src/bei_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bei_pkg
// shared widths, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
package bei_pkg;

	localparam int MAX_POINTS = 4096;
	localparam int ADDR_W     = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int TIME_W     = 40;
	localparam int VAL_W      = 32;
	localparam int STEP_W     = 24;
	localparam int FRAC_BITS  = 24;
	localparam int DIV_CNT_W  = $clog2(FRAC_BITS);
	localparam int ENTRY_W    = TIME_W + VAL_W;

	localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(349);

	// request command codes
	localparam logic [1:0] CMD_APPEND = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	// result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_HOLD = 2'd1;
	localparam logic [1:0] ST_FEW  = 2'd2;
	localparam logic [1:0] ST_FULL = 2'd3;

	typedef struct packed {
		logic       append;
		logic       clear;
		logic       emit_zero;
		logic [1:0] code;
		logic       rd_left;
		logic       rd_right;
		logic       rd_last;
		logic       cap_left;
		logic       cap_right;
		logic       prep;
		logic       div_step;
		logic       mul;
		logic       fin;
		logic       emit_hold;
	} bei_ctrl_t;

	typedef struct packed {
		logic few;
		logic play;
		logic full;
	} bei_stat_t;

endpackage

// ===== src/bei_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bei_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bei_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/bei_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bei_datapath
// point table, play state, restoring divider, multiplier and result registers
// ----------------------------------------------------------------------------
module bei_datapath
	import bei_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  bei_ctrl_t               ctrl,
	output bei_stat_t               stat,
	input  logic                    time_step_we,
	input  logic [STEP_W-1:0]       time_step,
	input  logic [TIME_W-1:0]       point_time,
	input  logic signed [VAL_W-1:0] point_value,
	output logic                    done,
	output logic signed [VAL_W-1:0] sample,
	output logic [1:0]              status,
	output logic [CNT_W-1:0]        stored_count
);

	logic [CNT_W-1:0]        total_q;
	logic [TIME_W-1:0]       pos_q;
	logic [ADDR_W-1:0]       li_q;
	logic                    active_q;
	logic [STEP_W-1:0]       step_q;
	logic [TIME_W-1:0]       t0_q, t1_q, width_q;
	logic signed [VAL_W-1:0] v0_q, v1_q;
	logic                    flat_q, one_q;
	logic [TIME_W-1:0]       rem_q;
	logic [FRAC_BITS:0]      quo_q;
	logic signed [VAL_W+FRAC_BITS+2:0] prod_q;

	logic [ADDR_W-1:0]  raddr;
	logic               re;
	logic [ENTRY_W-1:0] rdata;
	logic [CNT_W-1:0]   total_d;
	logic [TIME_W-1:0]  offset, width_c, new_pos;
	logic [TIME_W:0]    rem_sh;
	logic signed [VAL_W:0] height;
	logic signed [VAL_W+FRAC_BITS+2:0] prod_sh;
	logic signed [VAL_W-1:0] interp;

	assign stat.few  = total_q < CNT_W'(2);
	assign stat.play = active_q && ({1'b0, li_q} + CNT_W'(1) < total_q);
	assign stat.full = total_q == CNT_W'(MAX_POINTS);

	always_comb begin
		raddr = li_q;
		if (ctrl.rd_right) begin
			raddr = li_q + ADDR_W'(1);
		end else if (ctrl.rd_last) begin
			raddr = ADDR_W'(total_q - CNT_W'(1));
		end
	end
	assign re = ctrl.rd_left | ctrl.rd_right | ctrl.rd_last;

	bei_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_ram (
		.clk   (clk),
		.we    (ctrl.append & ~stat.full),
		.waddr (ADDR_W'(total_q)),
		.wdata ({point_time, point_value}),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_comb begin
		total_d = total_q;
		if (ctrl.clear) begin
			total_d = '0;
		end else if (ctrl.append && !stat.full) begin
			total_d = total_q + CNT_W'(1);
		end
	end

	// clamped offset into the segment
	assign width_c = t1_q - t0_q;
	always_comb begin
		offset = (pos_q > t0_q) ? pos_q - t0_q : '0;
		if (offset > width_c) begin
			offset = width_c;
		end
	end

	assign rem_sh  = {rem_q, 1'b0};
	assign height  = $signed({v1_q[VAL_W-1], v1_q}) - $signed({v0_q[VAL_W-1], v0_q});
	assign prod_sh = prod_q >>> FRAC_BITS;
	assign interp  = v0_q + prod_sh[VAL_W-1:0];
	assign new_pos = pos_q + TIME_W'(step_q);

	always_ff @(posedge clk) begin
		if (ctrl.cap_left) begin
			t0_q <= rdata[ENTRY_W-1:VAL_W];
			v0_q <= rdata[VAL_W-1:0];
		end
		if (ctrl.cap_right) begin
			t1_q <= rdata[ENTRY_W-1:VAL_W];
			v1_q <= rdata[VAL_W-1:0];
		end
		if (ctrl.prep) begin
			flat_q  <= t1_q <= t0_q;
			one_q   <= offset >= width_c;
			width_q <= width_c;
			rem_q   <= offset;
			quo_q   <= (offset >= width_c) ? (FRAC_BITS+1)'(1) << FRAC_BITS : '0;
		end else if (ctrl.div_step && !one_q) begin
			// remainder stays below the width, so it fits back in TIME_W bits
			if (rem_sh >= {1'b0, width_q}) begin
				rem_q <= TIME_W'(rem_sh - {1'b0, width_q});
				quo_q <= {quo_q[FRAC_BITS-1:0], 1'b1};
			end else begin
				rem_q <= rem_sh[TIME_W-1:0];
				quo_q <= {quo_q[FRAC_BITS-1:0], 1'b0};
			end
		end
		if (ctrl.mul) begin
			prod_q <= height * $signed({1'b0, quo_q});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			pos_q        <= '0;
			li_q         <= '0;
			active_q     <= 1'b1;
			step_q       <= STEP_RESET;
			done         <= 1'b0;
			sample       <= '0;
			status       <= ST_OK;
			stored_count <= '0;
		end else begin
			done <= 1'b0;
			if (time_step_we) begin
				step_q <= time_step;
			end
			total_q <= total_d;
			if (ctrl.clear) begin
				pos_q    <= '0;
				li_q     <= '0;
				active_q <= 1'b1;
			end
			if (ctrl.emit_zero) begin
				done         <= 1'b1;
				sample       <= '0;
				status       <= ctrl.code;
				stored_count <= total_d;
			end
			if (ctrl.emit_hold) begin
				active_q     <= 1'b0;
				done         <= 1'b1;
				sample       <= rdata[VAL_W-1:0];
				status       <= ST_HOLD;
				stored_count <= total_q;
			end
			if (ctrl.fin) begin
				done         <= 1'b1;
				sample       <= flat_q ? v1_q : interp;
				status       <= ST_OK;
				stored_count <= total_q;
				pos_q        <= new_pos;
				if (new_pos > t1_q) begin
					li_q <= li_q + ADDR_W'(1);
					if ({1'b0, li_q} + CNT_W'(2) >= total_q) begin
						active_q <= 1'b0;
					end
				end
			end
		end
	end

endmodule

// ===== src/bei_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bei_ctrl
// request sequencer: table read, divide, multiply and finish steps
// ----------------------------------------------------------------------------
module bei_ctrl
	import bei_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic [1:0] cmd,
	input  bei_stat_t stat,
	output bei_ctrl_t ctrl,
	output logic      busy
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RL   = 4'd1;
	localparam logic [3:0] S_RR   = 4'd2;
	localparam logic [3:0] S_PREP = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_MUL  = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_HRD  = 4'd7;

	logic [3:0]           state_q, state_d;
	logic [DIV_CNT_W-1:0] cnt_q;

	assign busy = state_q != S_IDLE;

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					case (cmd)
						CMD_APPEND: begin
							ctrl.append    = 1'b1;
							ctrl.emit_zero = 1'b1;
							ctrl.code      = stat.full ? ST_FULL : ST_OK;
						end
						CMD_TICK: begin
							if (stat.few) begin
								ctrl.emit_zero = 1'b1;
								ctrl.code      = ST_FEW;
							end else if (stat.play) begin
								ctrl.rd_left = 1'b1;
								state_d      = S_RL;
							end else begin
								ctrl.rd_last = 1'b1;
								state_d      = S_HRD;
							end
						end
						CMD_CLEAR: begin
							ctrl.clear     = 1'b1;
							ctrl.emit_zero = 1'b1;
							ctrl.code      = ST_OK;
						end
						default: begin
							ctrl.emit_zero = 1'b1;
							ctrl.code      = ST_OK;
						end
					endcase
				end
			end
			S_RL: begin
				ctrl.cap_left = 1'b1;
				ctrl.rd_right = 1'b1;
				state_d       = S_RR;
			end
			S_RR: begin
				ctrl.cap_right = 1'b1;
				state_d        = S_PREP;
			end
			S_PREP: begin
				ctrl.prep = 1'b1;
				state_d   = S_DIV;
			end
			S_DIV: begin
				ctrl.div_step = 1'b1;
				if (cnt_q == DIV_CNT_W'(FRAC_BITS - 1)) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				ctrl.mul = 1'b1;
				state_d  = S_FIN;
			end
			S_FIN: begin
				ctrl.fin = 1'b1;
				state_d  = S_IDLE;
			end
			S_HRD: begin
				ctrl.emit_hold = 1'b1;
				state_d        = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_DIV) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
			end else begin
				cnt_q <= '0;
			end
		end
	end

endmodule

// ===== src/breakpoint_envelope_interpolator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_envelope_interpolator
// linear interpolation over a table of (time, value) breakpoints
// ----------------------------------------------------------------------------
// append, clear and too-few-point ticks give their result in the cycle after
//   the request; a held tick reads the last point first, an interpolating
//   one reads both ends, divides in 24 restoring steps and multiplies while busy
// reset: asynchronous, empty table, position zero, time_step back to 349
// results are strobed by done for one cycle and cannot be stalled
module breakpoint_envelope_interpolator
	import bei_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic [1:0]              cmd,
	input  logic [TIME_W-1:0]       point_time,
	input  logic signed [VAL_W-1:0] point_value,
	input  logic                    time_step_we,
	input  logic [STEP_W-1:0]       time_step,
	output logic                    done,
	output logic signed [VAL_W-1:0] sample,
	output logic [1:0]              status,
	output logic [CNT_W-1:0]        stored_count
);

	// command and status between sequencer and datapath
	bei_ctrl_t ctrl;
	bei_stat_t stat;

	// sequencer: most requests finish in idle, ticks walk the table
	// read, divide and multiply steps
	bei_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.stat   (stat),
		.ctrl   (ctrl),
		.busy   (busy)
	);

	// datapath: point ram, play position, fraction divider and result regs
	bei_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.stat         (stat),
		.time_step_we (time_step_we),
		.time_step    (time_step),
		.point_time   (point_time),
		.point_value  (point_value),
		.done         (done),
		.sample       (sample),
		.status       (status),
		.stored_count (stored_count)
	);

endmodule

// ===== test/breakpoint_envelope_interpolator_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// breakpoint_envelope_interpolator_test
// self-checking bench: requests are queued by an initial block, sent by a
// clocked driver in bursts, and every strobed result is compared against a
// behavioural envelope predictor that mirrors the block's table and playhead
// ----------------------------------------------------------------------------
module breakpoint_envelope_interpolator_test;
	import bei_pkg::*;

	typedef enum logic [1:0] {ACT_REQUEST, ACT_SET_STEP, ACT_DRAIN} action_t;

	typedef struct {
		action_t                 act;
		logic [1:0]              op;
		logic [TIME_W-1:0]       when;
		logic signed [VAL_W-1:0] level;
		logic [STEP_W-1:0]       step;
	} pending_t;

	typedef struct {
		logic signed [VAL_W-1:0] sample;
		logic [1:0]              status;
		logic [CNT_W-1:0]        count;
	} outcome_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_CYCLES    = 40;

	// command code with no function
	localparam logic [1:0] CMD_SPARE = 2'd3;

	logic                    clk;
	logic                    arst_n;
	logic                    start;
	logic                    busy;
	logic [1:0]              cmd;
	logic [TIME_W-1:0]       point_time;
	logic signed [VAL_W-1:0] point_value;
	logic                    time_step_we;
	logic [STEP_W-1:0]       time_step;
	logic                    done;
	logic signed [VAL_W-1:0] sample;
	logic [1:0]              status;
	logic [CNT_W-1:0]        stored_count;

	breakpoint_envelope_interpolator u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.point_time   (point_time),
		.point_value  (point_value),
		.time_step_we (time_step_we),
		.time_step    (time_step),
		.done         (done),
		.sample       (sample),
		.status       (status),
		.stored_count (stored_count)
	);

	// clock, 2 ns period
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	pending_t pending_q[$];
	outcome_t envelope_q[$];
	int       results_owed;
	int       errors;

	// ------------------------------------------------------------------------
	// envelope predictor state
	// ------------------------------------------------------------------------
	logic [TIME_W-1:0]       bp_time[MAX_POINTS];
	logic signed [VAL_W-1:0] bp_value[MAX_POINTS];
	int                      bp_total;
	logic [TIME_W-1:0]       playhead;
	int                      seg_left;
	bit                      seg_live;
	logic [STEP_W-1:0]       step_now;

	// value at the playhead between breakpoints li and li+1
	function automatic logic signed [VAL_W-1:0] segment_value(int li);
		longint unsigned t0, t1, span, offset, frac, rem;
		longint          v0, v1, prod;
		t0 = bp_time[li];
		t1 = bp_time[li + 1];
		v0 = bp_value[li];
		v1 = bp_value[li + 1];
		// zero-width or backward segment jumps straight to the right value
		if (t1 <= t0)
			return v1[VAL_W-1:0];
		span   = t1 - t0;
		offset = (playhead > t0) ? playhead - t0 : 0;
		if (offset > span)
			offset = span;
		if (offset >= span) begin
			frac = 64'd1 << FRAC_BITS;
		end else begin
			rem  = offset;
			frac = 0;
			for (int i = 0; i < FRAC_BITS; i++) begin
				rem  = rem << 1;
				frac = frac << 1;
				if (rem >= span) begin
					rem  = rem - span;
					frac = frac | 64'd1;
				end
			end
		end
		// arithmetic shift floors toward minus infinity
		prod = (v1 - v0) * longint'(frac);
		return VAL_W'(v0 + (prod >>> FRAC_BITS));
	endfunction

	function automatic outcome_t predict_envelope(logic [1:0] op, logic [TIME_W-1:0] when,
			logic signed [VAL_W-1:0] level);
		outcome_t r;
		int       li;
		r.sample = '0;
		r.status = ST_OK;
		case (op)
			CMD_APPEND: begin
				if (bp_total < MAX_POINTS) begin
					bp_time[bp_total]  = when;
					bp_value[bp_total] = level;
					bp_total++;
				end else begin
					r.status = ST_FULL;
				end
			end
			CMD_TICK: begin
				if (bp_total < 2) begin
					r.status = ST_FEW;
				end else if (!seg_live || seg_left + 1 >= bp_total) begin
					seg_live = 1'b0;
					r.sample = bp_value[bp_total - 1];
					r.status = ST_HOLD;
				end else begin
					li       = seg_left;
					r.sample = segment_value(li);
					playhead = playhead + TIME_W'(step_now);
					if (playhead > bp_time[li + 1]) begin
						seg_left = li + 1;
						if (seg_left + 1 >= bp_total)
							seg_live = 1'b0;
					end
				end
			end
			CMD_CLEAR: begin
				bp_total = 0;
				playhead = '0;
				seg_left = 0;
				seg_live = 1'b1;
			end
			default: ;
		endcase
		r.count = CNT_W'(bp_total);
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus builders
	// ------------------------------------------------------------------------
	task automatic queue_request(logic [1:0] op, logic [TIME_W-1:0] when,
			logic signed [VAL_W-1:0] level);
		pending_t p;
		p.act   = ACT_REQUEST;
		p.op    = op;
		p.when  = when;
		p.level = level;
		p.step  = '0;
		pending_q.push_back(p);
	endtask

	task automatic queue_step(logic [STEP_W-1:0] step);
		pending_t p;
		p.act   = ACT_SET_STEP;
		p.op    = CMD_APPEND;
		p.when  = '0;
		p.level = '0;
		p.step  = step;
		pending_q.push_back(p);
	endtask

	task automatic queue_drain();
		pending_t p;
		p.act   = ACT_DRAIN;
		p.op    = CMD_APPEND;
		p.when  = '0;
		p.level = '0;
		p.step  = '0;
		pending_q.push_back(p);
	endtask

	function automatic logic signed [VAL_W-1:0] rand_level();
		case ($urandom_range(0, 3))
			0:       return $urandom;
			1:       return VAL_W'($signed($urandom_range(0, 4000)) - 2000);
			2:       return {1'b1, 31'($urandom)};
			default: return {1'b0, 31'($urandom)};
		endcase
	endfunction

	// directed corners, then random envelopes
	task automatic build_stimulus();
		int                n_items;
		int                n_pts;
		int                n_ticks;
		logic [STEP_W-1:0] step;
		logic [TIME_W-1:0] t;
		longint unsigned   stride;
		// fewer than two points, unused code, clear
		queue_request(CMD_TICK, '0, '0);
		queue_request(CMD_APPEND, 40'd0, 32'sh7fff_ffff);
		queue_request(CMD_TICK, '0, '0);
		queue_request(CMD_SPARE, '1, '1);
		queue_request(CMD_CLEAR, '1, '1);
		// falling, zero-width, backward and far segments with the reset step
		queue_request(CMD_APPEND, 40'd0, 32'sh7fff_ffff);
		queue_request(CMD_APPEND, 40'd1000, 32'sh8000_0000);
		queue_request(CMD_APPEND, 40'd1000, 32'sd5);
		queue_request(CMD_APPEND, 40'd500, 32'sd7);
		queue_request(CMD_APPEND, 40'hff_ffff_ffff, -32'sd1);
		repeat (9)
			queue_request(CMD_TICK, '0, '0);
		queue_drain();
		queue_step('1);
		queue_request(CMD_CLEAR, '0, '0);
		queue_request(CMD_APPEND, 40'd0, 32'sh8000_0000);
		queue_request(CMD_APPEND, 40'hff_ffff_ffff, 32'sh7fff_ffff);
		repeat (4)
			queue_request(CMD_TICK, '0, '0);
		queue_request(CMD_CLEAR, '0, '0);
		// random envelopes, each under its own step
		n_items = 0;
		while (n_items < 1850) begin
			case ($urandom_range(0, 4))
				0:       step = 24'd1;
				1:       step = '1;
				2:       step = STEP_W'($urandom_range(1, 2000));
				default: step = STEP_W'($urandom);
			endcase
			if (step == '0)
				step = 24'd1;
			queue_drain();
			queue_step(step);
			queue_request(CMD_CLEAR, '0, '0);
			n_pts = $urandom_range(2, 12);
			t     = ($urandom_range(0, 1)) ? '0 : TIME_W'($urandom_range(0, 3 * step));
			for (int i = 0; i < n_pts; i++) begin
				queue_request(CMD_APPEND, t, rand_level());
				stride = longint'(step) * $urandom_range(0, 6) + $urandom_range(0, step);
				case ($urandom_range(0, 9))
					0:       t = t - TIME_W'($urandom_range(0, step));
					1:       ;
					2:       t = TIME_W'({$urandom, $urandom});
					default: t = t + TIME_W'(stride);
				endcase
			end
			n_items += n_pts + 1;
			n_ticks = n_pts * 5 + $urandom_range(0, 6);
			for (int i = 0; i < n_ticks; i++) begin
				case ($urandom_range(0, 39))
					0, 1, 2: queue_request(CMD_APPEND, t + TIME_W'($urandom_range(0, 5 * step)),
							rand_level());
					3:       queue_request(CMD_SPARE, TIME_W'({$urandom, $urandom}), $urandom);
					4:       if ($urandom_range(0, 3) == 0)
								queue_request(CMD_CLEAR, '0, '0);
							 else
								queue_request(CMD_TICK, '0, '0);
					default: queue_request(CMD_TICK, TIME_W'({$urandom, $urandom}), $urandom);
				endcase
			end
			n_items += n_ticks;
		end
	endtask

	// ------------------------------------------------------------------------
	// driver: bursts of requests with random gaps, step writes only when idle
	// ------------------------------------------------------------------------
	int burst_left;
	int gap_left;

	always @(posedge clk) begin
		logic     we_next;
		logic     start_next;
		pending_t head;
		we_next    = 1'b0;
		start_next = start;
		if (!arst_n) begin
			start_next = 1'b0;
		end else if (!start || !busy) begin
			// nothing in flight on the request port
			start_next = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
			end else if (pending_q.size() > 0) begin
				head = pending_q[0];
				case (head.act)
					ACT_REQUEST: begin
						cmd         <= head.op;
						point_time  <= head.when;
						point_value <= head.level;
						start_next  = 1'b1;
						void'(pending_q.pop_front());
						if (--burst_left <= 0) begin
							burst_left = $urandom_range(1, 24);
							gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
						end
					end
					default: begin
						// hold off until every result is home and the block is quiet
						if (!start && results_owed == 0 && !busy && !done) begin
							if (head.act == ACT_SET_STEP) begin
								time_step <= head.step;
								we_next   = 1'b1;
							end
							void'(pending_q.pop_front());
						end
					end
				endcase
			end
		end
		start        <= start_next;
		time_step_we <= we_next;
	end

	// ------------------------------------------------------------------------
	// monitor: predicts on accepted requests, checks every strobed result
	// ------------------------------------------------------------------------
	int quiet_cycles;

	always @(posedge clk) begin
		outcome_t want;
		bit       took;
		took = arst_n && start && !busy;
		if (arst_n && time_step_we)
			step_now = time_step;
		if (arst_n && done) begin
			if (envelope_q.size() == 0) begin
				$display("%0t: unexpected result sample %0d status %0d count %0d",
					$time, sample, status, stored_count);
				errors++;
			end else begin
				want = envelope_q.pop_front();
				if (sample !== want.sample) begin
					$display("%0t: sample expected %0d actual %0d", $time, want.sample, sample);
					errors++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					errors++;
				end
				if (stored_count !== want.count) begin
					$display("%0t: stored_count expected %0d actual %0d",
						$time, want.count, stored_count);
					errors++;
				end
			end
		end
		if (took)
			envelope_q.push_back(predict_envelope(cmd, point_time, point_value));
		results_owed <= envelope_q.size();
		// watchdog on cycles with no traffic at all
		if (took || done || !arst_n) begin
			quiet_cycles = 0;
		end else if (++quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// reset, stimulus and end of run
	// ------------------------------------------------------------------------
	initial begin
		arst_n       = 1'b0;
		start        = 1'b0;
		cmd          = CMD_APPEND;
		point_time   = '0;
		point_value  = '0;
		time_step_we = 1'b0;
		time_step    = STEP_RESET;
		errors       = 0;
		results_owed = 0;
		quiet_cycles = 0;
		burst_left   = 8;
		gap_left     = 0;
		bp_total     = 0;
		playhead     = '0;
		seg_left     = 0;
		seg_live     = 1'b1;
		step_now     = STEP_RESET;
		build_stimulus();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		while (pending_q.size() > 0 || start || results_owed != 0 || envelope_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
		if (errors == 0 && envelope_q.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
